// ===== src/heading_hold_pid_drive_defines.svh =====
// Assertion macros for the heading-hold PID drive checker.
// Standalone header; no dependencies.
`ifndef HEADING_HOLD_PID_DRIVE_DEFINES_SVH
`define HEADING_HOLD_PID_DRIVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HHPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HHPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hhpd_pkg.sv =====
// Shared widths, constants, register indexes and stage structs for the
// heading-hold PID drive. No dependencies.
package hhpd_pkg;

    localparam int GAIN_W    = 24;
    localparam int HEAD_W    = 16;
    localparam int DIFF_W    = 18;
    localparam int ERR_W     = 16;
    localparam int DERR_W    = 17;
    localparam int INTEG_W   = 32;
    localparam int TARGET_W  = 24;
    localparam int BASE_W    = 7;
    localparam int SPEED_W   = 8;
    localparam int PKP_W     = GAIN_W + 1 + ERR_W;
    localparam int PKI_W     = GAIN_W + 1 + INTEG_W;
    localparam int PKD_W     = GAIN_W + 1 + DERR_W;
    localparam int SUM_W     = 60;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [DIFF_W-1:0]  HALF_TURN     = 18'sd18000;
    localparam logic signed [DIFF_W-1:0]  NEG_HALF_TURN = -18'sd18000;
    localparam logic signed [DIFF_W-1:0]  FULL_TURN     = 18'sd36000;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX     = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN     = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT   = 8'sd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 3'd0,
        CFG_KI       = 3'd1,
        CFG_KD       = 3'd2,
        CFG_SETPOINT = 3'd3,
        CFG_TARGET   = 3'd4,
        CFG_BASE     = 3'd5
    } t_cfg_idx;

    // error stage -> multiply stage
    typedef struct packed {
        logic                      running;
        logic                      reverse;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERR_W-1:0]  derr;
    } t_err_reg;

    // multiply stage -> mix stage
    typedef struct packed {
        logic                    running;
        logic                    reverse;
        logic signed [PKP_W-1:0] p_kp;
        logic signed [PKI_W-1:0] p_ki;
        logic signed [PKD_W-1:0] p_kd;
    } t_prod_reg;

endpackage

// ===== src/hhpd_err_stage.sv =====
// Heading error wrap, saturating integral, derivative term and run/done test.
// Holds the integral and previous-error state. Depends on hhpd_pkg.
module hhpd_err_stage
    import hhpd_pkg::*;
#(
    parameter int POSITION_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [HEAD_W-1:0]                 i_heading,
    input  logic signed [POSITION_WIDTH-1:0]  i_pos,
    input  logic [HEAD_W-1:0]                 i_setpoint,
    input  logic signed [TARGET_W-1:0]        i_target,
    output t_err_reg                          o_stage
);

    localparam int CMP_W = (POSITION_WIDTH > TARGET_W) ? POSITION_WIDTH : TARGET_W;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last;
    t_err_reg                  r_stage;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  wrap1;
    logic signed [DIFF_W-1:0]  wrap2;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [CMP_W-1:0]   pos_x;
    logic signed [CMP_W-1:0]   tgt_x;
    logic                      fwd;
    logic                      running;
    t_err_reg                  n_stage;

    always_comb begin
        diff  = $signed({2'b00, i_setpoint}) - $signed({2'b00, i_heading});
        wrap1 = (diff > HALF_TURN) ? diff - FULL_TURN : diff;
        wrap2 = (wrap1 < NEG_HALF_TURN) ? wrap1 + FULL_TURN : wrap1;
        err   = wrap2[ERR_W-1:0];

        integ_sum = INTEG_W'(r_integ) + (INTEG_W + 1)'(err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end

        pos_x   = CMP_W'(i_pos);
        tgt_x   = CMP_W'(i_target);
        fwd     = (i_target > 0);
        running = fwd ? (pos_x < tgt_x) : (pos_x > tgt_x);

        n_stage.running = running;
        n_stage.reverse = ~fwd;
        n_stage.err     = err;
        n_stage.integ   = integ_sat;
        n_stage.derr    = DERR_W'(err) - DERR_W'(r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_load && running) begin
            r_integ <= integ_sat;
            r_last  <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== src/hhpd_mult_stage.sv =====
// Three parallel gain multiplies (P, I, D terms), registered.
// Depends on hhpd_pkg.
module hhpd_mult_stage
    import hhpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  t_err_reg          i_stage,
    input  logic [GAIN_W-1:0] i_kp,
    input  logic [GAIN_W-1:0] i_ki,
    input  logic [GAIN_W-1:0] i_kd,
    output t_prod_reg         o_stage
);

    t_prod_reg r_stage;
    t_prod_reg n_stage;

    always_comb begin
        n_stage.running = i_stage.running;
        n_stage.reverse = i_stage.reverse;
        n_stage.p_kp    = $signed({1'b0, i_kp}) * i_stage.err;
        n_stage.p_ki    = $signed({1'b0, i_ki}) * i_stage.integ;
        n_stage.p_kd    = $signed({1'b0, i_kd}) * i_stage.derr;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== src/hhpd_mix_stage.sv =====
// Correction sum, left/right mix, half-up rounding and +-100 clamp; both sides are zero when done.
// Result register of the pipeline. Depends on hhpd_pkg.
module hhpd_mix_stage
    import hhpd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  t_prod_reg                  i_stage,
    input  logic [BASE_W-1:0]          i_base,
    output logic signed [SPEED_W-1:0]  o_right,
    output logic signed [SPEED_W-1:0]  o_left,
    output logic                       o_reverse,
    output logic                       o_done
);

    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] MAX_Q    = SUM_W'(SPEED_LIMIT);
    localparam logic signed [SUM_W-1:0] MIN_Q    = -SUM_W'(SPEED_LIMIT);

    function automatic logic signed [SPEED_W-1:0] round_sat(input logic signed [SUM_W-1:0] q);
        logic signed [SUM_W-1:0] r;
        r = (q + HALF_LSB) >>> GAIN_FRAC_BITS;
        if (r > MAX_Q) begin
            r = MAX_Q;
        end else if (r < MIN_Q) begin
            r = MIN_Q;
        end
        return r[SPEED_W-1:0];
    endfunction

    logic signed [SUM_W-1:0]   corr;
    logic signed [SUM_W-1:0]   base_q;
    logic signed [SPEED_W-1:0] n_right;
    logic signed [SPEED_W-1:0] n_left;

    logic signed [SPEED_W-1:0] r_right;
    logic signed [SPEED_W-1:0] r_left;
    logic                      r_reverse;
    logic                      r_done;

    always_comb begin
        corr   = SUM_W'(i_stage.p_kp) + SUM_W'(i_stage.p_ki) + SUM_W'(i_stage.p_kd);
        base_q = SUM_W'($signed({1'b0, i_base})) <<< GAIN_FRAC_BITS;
        if (i_stage.running) begin
            n_right = round_sat(base_q - corr);
            n_left  = round_sat(base_q + corr);
        end else begin
            n_right = '0;
            n_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_right   <= n_right;
            r_left    <= n_left;
            r_reverse <= i_stage.reverse;
            r_done    <= ~i_stage.running;
        end
    end

    assign o_right   = r_right;
    assign o_left    = r_left;
    assign o_reverse = r_reverse;
    assign o_done    = r_done;

endmodule

// ===== src/heading_hold_pid_drive.sv =====
// Top level of the heading-hold PID drive: config registers, input register,
// pipeline valid/ready control. Depends on hhpd_pkg and the hhpd_* stages.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    heading_cdeg, wheel_position
//   result    out        o_out_valid / i_out_ready  right/left speed, reverse, done
//   config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// Four register stages: input, error/integral, multiply, result.
// One transaction per cycle while the result is not stalled.
// The integral/previous-error recurrence closes inside the error stage.
// Each stage loads when empty or when its successor takes its contents, so
// a stalled result still lets upstream stages fill.
// Synchronous active-low reset clears valids, config and controller state.
module heading_hold_pid_drive
    import hhpd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16,
    parameter int POSITION_WIDTH = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [HEAD_W-1:0]                i_heading_cdeg,
    input  logic signed [POSITION_WIDTH-1:0] i_wheel_position,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [SPEED_W-1:0]        o_right_speed,
    output logic signed [SPEED_W-1:0]        o_left_speed,
    output logic                             o_reverse_drive,
    output logic                             o_done_res,
    input  logic                             i_cfg_we,
    input  logic [CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data
);

    logic [GAIN_W-1:0]          r_kp;
    logic [GAIN_W-1:0]          r_ki;
    logic [GAIN_W-1:0]          r_kd;
    logic [HEAD_W-1:0]          r_setpoint;
    logic signed [TARGET_W-1:0] r_target;
    logic [BASE_W-1:0]          r_base;

    logic                             r_v0, r_v1, r_v2, r_v3;
    logic [HEAD_W-1:0]                r_heading;
    logic signed [POSITION_WIDTH-1:0] r_pos;

    logic rdy0, rdy1, rdy2, rdy3;
    logic ld0, ld1, ld2, ld3;

    t_err_reg  err_stage;
    t_prod_reg prod_stage;

    // ready chain, result register back to input
    assign rdy3 = ~r_v3 | i_out_ready;
    assign rdy2 = ~r_v2 | rdy3;
    assign rdy1 = ~r_v1 | rdy2;
    assign rdy0 = ~r_v0 | rdy1;

    assign ld0 = rdy0 & i_in_valid;
    assign ld1 = rdy1 & r_v0;
    assign ld2 = rdy2 & r_v1;
    assign ld3 = rdy3 & r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_setpoint <= '0;
            r_target   <= '0;
            r_base     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP:       r_kp       <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:       r_ki       <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:       r_kd       <= i_cfg_data[GAIN_W-1:0];
                CFG_SETPOINT: r_setpoint <= i_cfg_data[HEAD_W-1:0];
                CFG_TARGET:   r_target   <= $signed(i_cfg_data[TARGET_W-1:0]);
                CFG_BASE:     r_base     <= i_cfg_data[BASE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_in_valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_heading <= i_heading_cdeg;
            r_pos     <= i_wheel_position;
        end
    end

    hhpd_err_stage #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ld1),
        .i_heading  (r_heading),
        .i_pos      (r_pos),
        .i_setpoint (r_setpoint),
        .i_target   (r_target),
        .o_stage    (err_stage)
    );

    hhpd_mult_stage u_mult (
        .i_clk   (i_clk),
        .i_load  (ld2),
        .i_stage (err_stage),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .o_stage (prod_stage)
    );

    hhpd_mix_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mix (
        .i_clk     (i_clk),
        .i_load    (ld3),
        .i_stage   (prod_stage),
        .i_base    (r_base),
        .o_right   (o_right_speed),
        .o_left    (o_left_speed),
        .o_reverse (o_reverse_drive),
        .o_done    (o_done_res)
    );

    assign o_in_ready  = rdy0;
    assign o_out_valid = r_v3;

endmodule

// ===== src/hhpd_checker.sv =====
// Port-level checks for heading_hold_pid_drive, bound to the top level.
// Depends on hhpd_pkg and heading_hold_pid_drive_defines.svh.
`include "heading_hold_pid_drive_defines.svh"

module hhpd_checker
    import hhpd_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [SPEED_W-1:0] o_right_speed,
    input logic signed [SPEED_W-1:0] o_left_speed,
    input logic                      o_reverse_drive,
    input logic                      o_done_res
);

    // a done result brakes both sides
    `HHPD_ASSERT_SAME(a_done_zero, i_clk, i_rst_n, o_out_valid && o_done_res, o_right_speed == 0 && o_left_speed == 0, "done result with nonzero speed")

    // clamp holds on both sides
    `HHPD_ASSERT_SAME(a_speed_range, i_clk, i_rst_n, o_out_valid, o_right_speed >= -SPEED_LIMIT && o_right_speed <= SPEED_LIMIT && o_left_speed >= -SPEED_LIMIT && o_left_speed <= SPEED_LIMIT, "speed outside +-100")

    // empty result register means the whole pipe can take a transaction
    `HHPD_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty result register")

    // stalled result holds
    `HHPD_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_right_speed) && $stable(o_left_speed) && $stable(o_reverse_drive) && $stable(o_done_res), "stalled result changed")

endmodule

bind heading_hold_pid_drive hhpd_checker u_hhpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_right_speed   (o_right_speed),
    .o_left_speed    (o_left_speed),
    .o_reverse_drive (o_reverse_drive),
    .o_done_res      (o_done_res)
);
